// ===== hw/rtl/printf_format_spec_parser_core_macros.svh =====
// Assertion macros for the checker file.
`ifndef PRINTF_FORMAT_SPEC_PARSER_CORE_MACROS_SVH
`define PRINTF_FORMAT_SPEC_PARSER_CORE_MACROS_SVH

// Same-cycle implication, quiet while reset is asserted.
`define PFSP_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, quiet while reset is asserted.
`define PFSP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hw/rtl/pfsp_pkg.sv =====
package pfsp_pkg;

	// Default width of the numeric fields
	localparam int NUMBER_BITS_DEF = 16;

	typedef enum logic [3:0] {
		PH_IDLE    = 4'd0,
		PH_FLAGS   = 4'd1,
		PH_WDIG    = 4'd2,
		PH_WSTAR   = 4'd3,
		PH_PDOT    = 4'd4,
		PH_PDIG    = 4'd5,
		PH_PSTAR   = 4'd6,
		PH_LEN     = 4'd7,
		PH_AFTER_H = 4'd8,
		PH_AFTER_L = 4'd9,
		PH_CONV    = 4'd10
	} phase_t;

	typedef enum logic [1:0] {
		ARG_NONE = 2'd0,
		ARG_STAR = 2'd1,
		ARG_POS  = 2'd2
	} arg_mode_t;

	typedef enum logic [2:0] {
		LEN_NONE = 3'd0,
		LEN_H    = 3'd1,
		LEN_L    = 3'd2,
		LEN_HH   = 3'd3,
		LEN_LL   = 3'd4,
		LEN_Z    = 3'd5,
		LEN_J    = 3'd6,
		LEN_BIGL = 3'd7
	} len_code_t;

	typedef enum logic [1:0] {
		ST_VALID   = 2'd0,
		ST_LITERAL = 2'd1,
		ST_END     = 2'd2
	} status_t;

	// Flag bit positions
	localparam int FLAG_MINUS = 0;
	localparam int FLAG_PLUS  = 1;
	localparam int FLAG_ALT   = 2;
	localparam int FLAG_SPACE = 3;
	localparam int FLAG_ZERO  = 4;

	// Parser control state (numeric accumulators travel separately)
	typedef struct packed {
		phase_t    phase;
		logic [4:0] flags;
		arg_mode_t wmode;
		logic      pseen;
		arg_mode_t pmode;
		len_code_t len;
	} ctl_t;

	localparam ctl_t CTL_CLEAR = '{
		phase: PH_IDLE, flags: 5'd0, wmode: ARG_NONE,
		pseen: 1'b0, pmode: ARG_NONE, len: LEN_NONE
	};

	// Result descriptor for one character step
	typedef struct packed {
		logic       emit;
		logic [7:0] conv;
		status_t    status;
		len_code_t  len;
	} res_t;

	// Accepted conversion characters
	function automatic logic is_conv(input logic [7:0] c);
		logic hit;
		hit = c inside {"c", "C", "s", "S", "p", "d", "D", "i", "o", "O", "u",
			"U", "x", "X", "f", "F", "e", "E", "g", "G", "b", "B"};
		return hit;
	endfunction

endpackage

// ===== hw/rtl/pfsp_digit_acc.sv =====
// Decimal accumulate: acc * 10 + digit, saturating at all ones.
module pfsp_digit_acc #(
	parameter int NUMBER_BITS = pfsp_pkg::NUMBER_BITS_DEF
) (
	input  logic [NUMBER_BITS-1:0] acc,
	input  logic [7:0]             ch,
	output logic [NUMBER_BITS-1:0] sum
);

	logic [NUMBER_BITS+3:0] times_ten;
	logic [NUMBER_BITS+3:0] total;
	logic [3:0]             digit;

	// x10 as x8 + x2, then add the digit value
	assign digit     = 4'(ch - 8'h30);
	assign times_ten = {1'b0, acc, 3'b000} + {3'b000, acc, 1'b0};
	assign total     = times_ten + {{NUMBER_BITS{1'b0}}, digit};
	assign sum       = (total[NUMBER_BITS+3:NUMBER_BITS] != 4'd0) ?
		{NUMBER_BITS{1'b1}} : total[NUMBER_BITS-1:0];

endmodule

// ===== hw/rtl/pfsp_step.sv =====
// One character of the specifier: phase walk, field updates, result decode.
module pfsp_step #(
	parameter int NUMBER_BITS = pfsp_pkg::NUMBER_BITS_DEF
) (
	input  logic [7:0]             ch,
	input  logic                   end_of_text,
	input  pfsp_pkg::ctl_t         cur,
	input  logic [NUMBER_BITS-1:0] wacc,
	input  logic [NUMBER_BITS-1:0] widx,
	input  logic [NUMBER_BITS-1:0] pacc,
	input  logic [NUMBER_BITS-1:0] pidx,
	output pfsp_pkg::ctl_t         nxt,
	output logic [NUMBER_BITS-1:0] wacc_nxt,
	output logic [NUMBER_BITS-1:0] widx_nxt,
	output logic [NUMBER_BITS-1:0] pacc_nxt,
	output logic [NUMBER_BITS-1:0] pidx_nxt,
	output pfsp_pkg::res_t         res
);

	logic [NUMBER_BITS-1:0] wacc_dig;
	logic [NUMBER_BITS-1:0] pacc_dig;

	// Digit accumulators run in parallel; the phase walk picks one
	pfsp_digit_acc #(.NUMBER_BITS(NUMBER_BITS)) u_wacc (
		.acc(wacc), .ch(ch), .sum(wacc_dig)
	);

	pfsp_digit_acc #(.NUMBER_BITS(NUMBER_BITS)) u_pacc (
		.acc(pacc), .ch(ch), .sum(pacc_dig)
	);

	// Phases only move forward, so the fall-through is a chain of checks
	always_comb begin
		pfsp_pkg::phase_t ph;
		logic done;
		logic is_end;
		logic idle_path;
		logic is_digit;

		nxt       = cur;
		wacc_nxt  = wacc;
		widx_nxt  = widx;
		pacc_nxt  = pacc;
		pidx_nxt  = pidx;
		res.emit   = 1'b0;
		res.conv   = 8'h00;
		res.status = pfsp_pkg::ST_VALID;
		res.len    = pfsp_pkg::LEN_NONE;
		ph        = cur.phase;
		done      = 1'b0;
		is_end    = end_of_text || (ch == 8'h00);
		is_digit  = ch inside {["0":"9"]};
		idle_path = (cur.phase == pfsp_pkg::PH_IDLE) || (cur.phase > pfsp_pkg::PH_CONV);

		// Introducer or stray end while idle
		if (idle_path) begin
			done = 1'b1;
			if (is_end) begin
				nxt.phase = pfsp_pkg::PH_IDLE;
			end else begin
				nxt       = pfsp_pkg::CTL_CLEAR;
				nxt.phase = pfsp_pkg::PH_FLAGS;
				wacc_nxt  = '0;
				widx_nxt  = '0;
				pacc_nxt  = '0;
				pidx_nxt  = '0;
			end
		end else if (is_end) begin
			done       = 1'b1;
			res.emit   = 1'b1;
			res.status = pfsp_pkg::ST_END;
			case (cur.phase)
				pfsp_pkg::PH_AFTER_H: res.len = pfsp_pkg::LEN_H;
				pfsp_pkg::PH_AFTER_L: res.len = pfsp_pkg::LEN_L;
				default:              res.len = cur.len;
			endcase
		end

		// Flags
		if (!done && ph == pfsp_pkg::PH_FLAGS) begin
			done = 1'b1;
			case (ch)
				"-":     nxt.flags[pfsp_pkg::FLAG_MINUS] = 1'b1;
				"+":     nxt.flags[pfsp_pkg::FLAG_PLUS]  = 1'b1;
				"#":     nxt.flags[pfsp_pkg::FLAG_ALT]   = 1'b1;
				" ":     nxt.flags[pfsp_pkg::FLAG_SPACE] = 1'b1;
				"0":     nxt.flags[pfsp_pkg::FLAG_ZERO]  = 1'b1;
				default: begin
					done = 1'b0;
					ph   = pfsp_pkg::PH_WDIG;
				end
			endcase
		end

		// Width digits, star, dollar
		if (!done && ph == pfsp_pkg::PH_WDIG) begin
			done = 1'b1;
			if (is_digit) begin
				wacc_nxt = wacc_dig;
			end else if (ch == "*") begin
				nxt.wmode = pfsp_pkg::ARG_STAR;
				wacc_nxt  = '0;
				ph        = pfsp_pkg::PH_WSTAR;
			end else if (ch == "$") begin
				nxt.wmode = pfsp_pkg::ARG_POS;
				widx_nxt  = wacc;
				wacc_nxt  = '0;
				ph        = pfsp_pkg::PH_PDOT;
			end else begin
				done = 1'b0;
				ph   = pfsp_pkg::PH_PDOT;
			end
		end

		if (!done && ph == pfsp_pkg::PH_WSTAR) begin
			if (ch == "$") begin
				done      = 1'b1;
				nxt.wmode = pfsp_pkg::ARG_POS;
				widx_nxt  = '0;
			end
			ph = pfsp_pkg::PH_PDOT;
		end

		// Precision dot
		if (!done && ph == pfsp_pkg::PH_PDOT) begin
			if (ch == ".") begin
				done      = 1'b1;
				nxt.pseen = 1'b1;
				ph        = pfsp_pkg::PH_PDIG;
			end else begin
				ph = pfsp_pkg::PH_LEN;
			end
		end

		// Precision digits, star, dollar
		if (!done && ph == pfsp_pkg::PH_PDIG) begin
			done = 1'b1;
			if (is_digit) begin
				pacc_nxt = pacc_dig;
			end else if (ch == "*") begin
				nxt.pmode = pfsp_pkg::ARG_STAR;
				pacc_nxt  = '0;
				ph        = pfsp_pkg::PH_PSTAR;
			end else if (ch == "$") begin
				nxt.pmode = pfsp_pkg::ARG_POS;
				pidx_nxt  = pacc;
				pacc_nxt  = '0;
				ph        = pfsp_pkg::PH_LEN;
			end else begin
				done = 1'b0;
				ph   = pfsp_pkg::PH_LEN;
			end
		end

		if (!done && ph == pfsp_pkg::PH_PSTAR) begin
			if (ch == "$") begin
				done      = 1'b1;
				nxt.pmode = pfsp_pkg::ARG_POS;
				pidx_nxt  = '0;
			end
			ph = pfsp_pkg::PH_LEN;
		end

		// Length modifier
		if (!done && ph == pfsp_pkg::PH_LEN) begin
			done = 1'b1;
			case (ch)
				"h":     ph = pfsp_pkg::PH_AFTER_H;
				"l":     ph = pfsp_pkg::PH_AFTER_L;
				"z":     begin nxt.len = pfsp_pkg::LEN_Z;    ph = pfsp_pkg::PH_CONV; end
				"j":     begin nxt.len = pfsp_pkg::LEN_J;    ph = pfsp_pkg::PH_CONV; end
				"L":     begin nxt.len = pfsp_pkg::LEN_BIGL; ph = pfsp_pkg::PH_CONV; end
				default: begin
					done = 1'b0;
					ph   = pfsp_pkg::PH_CONV;
				end
			endcase
		end

		if (!done && ph == pfsp_pkg::PH_AFTER_H) begin
			if (ch == "h") begin
				done    = 1'b1;
				nxt.len = pfsp_pkg::LEN_HH;
			end else begin
				nxt.len = pfsp_pkg::LEN_H;
			end
			ph = pfsp_pkg::PH_CONV;
		end

		if (!done && ph == pfsp_pkg::PH_AFTER_L) begin
			if (ch == "l") begin
				done    = 1'b1;
				nxt.len = pfsp_pkg::LEN_LL;
			end else begin
				nxt.len = pfsp_pkg::LEN_L;
			end
			ph = pfsp_pkg::PH_CONV;
		end

		// Conversion character closes the specifier
		if (!done && ph == pfsp_pkg::PH_CONV) begin
			res.emit = 1'b1;
			res.conv = ch;
			if (pfsp_pkg::is_conv(ch)) begin
				res.status = pfsp_pkg::ST_VALID;
				res.len    = nxt.len;
			end else begin
				res.status = pfsp_pkg::ST_LITERAL;
				res.len    = pfsp_pkg::LEN_NONE;
			end
		end

		if (!idle_path) begin
			nxt.phase = ph;
		end

		// Result fields come from the current stores; state returns to idle
		if (res.emit) begin
			nxt      = pfsp_pkg::CTL_CLEAR;
			wacc_nxt = '0;
			widx_nxt = '0;
			pacc_nxt = '0;
			pidx_nxt = '0;
		end
	end

endmodule

// ===== hw/rtl/printf_format_spec_parser_core.sv =====
// Format specifier parser: takes one character per request on the item channel,
// starting with the introducer (ignored), and returns one result per specifier
// when the conversion character or end of text (end_of_text, or a NUL character)
// arrives. A new character is taken every cycle unless the result register stalls;
// the closing character passes through the input register and the combinational parse
// step into the result register. Throughput holds at one character per cycle while
// result_ready is high, since the result register and the input register each take
// new data in the cycle they are drained.
module printf_format_spec_parser_core #(
	parameter int NUMBER_BITS = pfsp_pkg::NUMBER_BITS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   item_valid,
	output logic                   item_ready,
	input  logic [7:0]             ch,
	input  logic                   end_of_text,
	output logic                   result_valid,
	input  logic                   result_ready,
	output logic [4:0]             flag_bits,
	output logic [NUMBER_BITS-1:0] width,
	output logic [1:0]             width_arg_mode,
	output logic [NUMBER_BITS-1:0] width_arg_index,
	output logic [NUMBER_BITS-1:0] precision,
	output logic                   precision_present,
	output logic [1:0]             precision_arg_mode,
	output logic [NUMBER_BITS-1:0] precision_arg_index,
	output logic [2:0]             length_code,
	output logic [7:0]             conversion,
	output logic [1:0]             status
);

	logic                   valid_s1;
	logic [7:0]             ch_s1;
	logic                   eot_s1;
	logic                   advance;
	logic                   fire;
	pfsp_pkg::ctl_t         ctl_q;
	pfsp_pkg::ctl_t         ctl_nxt;
	logic [NUMBER_BITS-1:0] wacc_q;
	logic [NUMBER_BITS-1:0] widx_q;
	logic [NUMBER_BITS-1:0] pacc_q;
	logic [NUMBER_BITS-1:0] pidx_q;
	logic [NUMBER_BITS-1:0] wacc_nxt;
	logic [NUMBER_BITS-1:0] widx_nxt;
	logic [NUMBER_BITS-1:0] pacc_nxt;
	logic [NUMBER_BITS-1:0] pidx_nxt;
	pfsp_pkg::res_t         res;
	logic                   out_valid_q;

	// Handshake: result register frees when empty or drained this cycle
	assign advance    = !out_valid_q || result_ready;
	assign fire       = valid_s1 && advance;
	assign item_ready = !valid_s1 || advance;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item_ready) begin
			valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item_ready && item_valid) begin
			ch_s1  <= ch;
			eot_s1 <= end_of_text;
		end
	end

	pfsp_step #(.NUMBER_BITS(NUMBER_BITS)) u_step (
		.ch          (ch_s1),
		.end_of_text (eot_s1),
		.cur         (ctl_q),
		.wacc        (wacc_q),
		.widx        (widx_q),
		.pacc        (pacc_q),
		.pidx        (pidx_q),
		.nxt         (ctl_nxt),
		.wacc_nxt    (wacc_nxt),
		.widx_nxt    (widx_nxt),
		.pacc_nxt    (pacc_nxt),
		.pidx_nxt    (pidx_nxt),
		.res         (res)
	);

	// Parser state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_q <= pfsp_pkg::CTL_CLEAR;
		end else if (fire) begin
			ctl_q <= ctl_nxt;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			wacc_q <= wacc_nxt;
			widx_q <= widx_nxt;
			pacc_q <= pacc_nxt;
			pidx_q <= pidx_nxt;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= fire && res.emit;
		end
	end

	always_ff @(posedge clk) begin
		if (fire && res.emit) begin
			flag_bits           <= ctl_q.flags;
			width               <= wacc_q;
			width_arg_mode      <= ctl_q.wmode;
			width_arg_index     <= widx_q;
			precision           <= pacc_q;
			precision_present   <= ctl_q.pseen;
			precision_arg_mode  <= ctl_q.pmode;
			precision_arg_index <= pidx_q;
			length_code         <= res.len;
			conversion          <= res.conv;
			status              <= res.status;
		end
	end

	assign result_valid = out_valid_q;

endmodule

// ===== hw/rtl/pfsp_checker.sv =====
`include "printf_format_spec_parser_core_macros.svh"

// Port-level checks on the parser's result channel.
module pfsp_checker #(
	parameter int NUMBER_BITS = pfsp_pkg::NUMBER_BITS_DEF
) (
	input logic                   clk,
	input logic                   arst_n,
	input logic                   result_valid,
	input logic                   result_ready,
	input logic [NUMBER_BITS-1:0] width,
	input logic [1:0]             width_arg_mode,
	input logic [NUMBER_BITS-1:0] precision,
	input logic                   precision_present,
	input logic [1:0]             precision_arg_mode,
	input logic [2:0]             length_code,
	input logic [7:0]             conversion,
	input logic [1:0]             status
);

	// End of text carries no character
	`PFSP_ASSERT_NOW(a_end_no_conv, clk, arst_n, result_valid && status == pfsp_pkg::ST_END, conversion == 8'h00, "end-of-text result with nonzero conversion")

	// A literal never carries a length modifier
	`PFSP_ASSERT_NOW(a_literal_no_len, clk, arst_n, result_valid && status == pfsp_pkg::ST_LITERAL, length_code == pfsp_pkg::LEN_NONE, "literal result with length code")

	// Star or positional width leaves no direct width value
	`PFSP_ASSERT_NOW(a_wmode_zero, clk, arst_n, result_valid && width_arg_mode != pfsp_pkg::ARG_NONE, width == '0, "argument width with nonzero width value")

	// Precision argument modes only follow a dot, and clear the value
	`PFSP_ASSERT_NOW(a_pmode_dot, clk, arst_n, result_valid && precision_arg_mode != pfsp_pkg::ARG_NONE, precision_present && precision == '0, "precision mode without dot or with value")

	// A stalled result holds
	`PFSP_ASSERT_NEXT(a_hold, clk, arst_n, result_valid && !result_ready, result_valid && $stable(conversion) && $stable(status), "stalled result changed")

endmodule

bind printf_format_spec_parser_core pfsp_checker #(.NUMBER_BITS(NUMBER_BITS)) u_pfsp_checker (
	.clk                (clk),
	.arst_n             (arst_n),
	.result_valid       (result_valid),
	.result_ready       (result_ready),
	.width              (width),
	.width_arg_mode     (width_arg_mode),
	.precision          (precision),
	.precision_present  (precision_present),
	.precision_arg_mode (precision_arg_mode),
	.length_code        (length_code),
	.conversion         (conversion),
	.status             (status)
);

// ===== test/tb_printf_format_spec_parser_core.sv =====
`timescale 1ns / 100ps

module tb_printf_format_spec_parser_core;
	import pfsp_pkg::*;

	localparam int NB = NUMBER_BITS_DEF;
	localparam logic [NB-1:0] NUM_SAT = {NB{1'b1}};
	localparam string CONV_SET = "cCsSpdDioOuUxXfFeEgGbB";
	localparam string FLAG_SET = "-+# 0";
	localparam int HOLD_OFF_AT = 150;
	localparam int HOLD_OFF_CYCLES = 300;
	localparam int PAUSE_AT = 280;
	localparam int CALM_FROM = 350;
	localparam int CALM_TO = 450;
	localparam int IDLE_PCT = 15;

	// One character request for the item channel
	typedef struct {
		logic [7:0] c;
		logic       eot;
		logic       hold;
	} char_req_t;

	// One parsed specifier as the block should report it
	typedef struct {
		logic [4:0]    flags;
		logic [NB-1:0] wval;
		arg_mode_t     wmode;
		logic [NB-1:0] widx;
		logic [NB-1:0] pval;
		logic          pseen;
		arg_mode_t     pmode;
		logic [NB-1:0] pidx;
		len_code_t     len;
		logic [7:0]    conv;
		status_t       status;
	} spec_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic item_valid = 1'b0;
	logic item_ready;
	logic [7:0] ch = 8'd0;
	logic end_of_text = 1'b0;
	logic result_valid;
	logic result_ready = 1'b0;
	logic [4:0] flag_bits;
	logic [NB-1:0] width;
	logic [1:0] width_arg_mode;
	logic [NB-1:0] width_arg_index;
	logic [NB-1:0] precision;
	logic precision_present;
	logic [1:0] precision_arg_mode;
	logic [NB-1:0] precision_arg_index;
	logic [2:0] length_code;
	logic [7:0] conversion;
	logic [1:0] status;

	char_req_t char_q[$];
	spec_t spec_q[$];
	int total_chars = 0;
	int chars_sent = 0;
	int errors = 0;
	int n_valid = 0;
	int n_literal = 0;
	int n_ended = 0;
	int hold_left = 0;
	bit hold_done = 1'b0;
	int pause_specs = 3;

	// Parser state mirror
	phase_t ph = PH_IDLE;
	logic [4:0] fl = '0;
	logic [NB-1:0] wacc = '0;
	arg_mode_t wm = ARG_NONE;
	logic [NB-1:0] widx = '0;
	logic [NB-1:0] pacc = '0;
	logic pseen = 1'b0;
	arg_mode_t pm = ARG_NONE;
	logic [NB-1:0] pidx = '0;
	len_code_t lenc = LEN_NONE;

	printf_format_spec_parser_core #(.NUMBER_BITS(NB)) uut (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_ready(item_ready),
		.ch(ch),
		.end_of_text(end_of_text),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.flag_bits(flag_bits),
		.width(width),
		.width_arg_mode(width_arg_mode),
		.width_arg_index(width_arg_index),
		.precision(precision),
		.precision_present(precision_present),
		.precision_arg_mode(precision_arg_mode),
		.precision_arg_index(precision_arg_index),
		.length_code(length_code),
		.conversion(conversion),
		.status(status)
	);

	always #2 clk = ~clk;

	// ---------------- specifier predictor ----------------

	function automatic bit is_digit(input logic [7:0] c);
		return c >= "0" && c <= "9";
	endfunction

	function automatic bit known_conv(input logic [7:0] c);
		case (c)
			"c", "C", "s", "S", "p", "d", "D", "i", "o", "O", "u", "U",
			"x", "X", "f", "F", "e", "E", "g", "G", "b", "B": return 1'b1;
			default: return 1'b0;
		endcase
	endfunction

	// Decimal accumulate, saturating at the field maximum
	function automatic logic [NB-1:0] add_digit(input logic [NB-1:0] acc, input logic [7:0] c);
		logic [NB+7:0] v;
		v = {8'd0, acc} * (NB+8)'(10) + (NB+8)'(c - 8'h30);
		return (v > NUM_SAT) ? NUM_SAT : v[NB-1:0];
	endfunction

	task automatic clear_fields();
		ph = PH_IDLE;
		fl = '0;
		wacc = '0;
		wm = ARG_NONE;
		widx = '0;
		pacc = '0;
		pseen = 1'b0;
		pm = ARG_NONE;
		pidx = '0;
		lenc = LEN_NONE;
	endtask

	task automatic close_spec(input logic [7:0] conv, input status_t st, input len_code_t len);
		spec_t s;
		s.flags = fl;
		s.wval = wacc;
		s.wmode = wm;
		s.widx = widx;
		s.pval = pacc;
		s.pseen = pseen;
		s.pmode = pm;
		s.pidx = pidx;
		s.len = len;
		s.conv = conv;
		s.status = st;
		spec_q.push_back(s);
		clear_fields();
	endtask

	// Advance the parser by one accepted character
	task automatic parse_char(input logic [7:0] c, input logic eot);
		logic ends;
		ends = eot || (c == 8'd0);
		if (ph == PH_IDLE) begin
			// introducer is swallowed; an end while idle does nothing
			if (!ends) begin
				clear_fields();
				ph = PH_FLAGS;
			end
			return;
		end
		if (ends) begin
			if (ph == PH_AFTER_H)
				lenc = LEN_H;
			else if (ph == PH_AFTER_L)
				lenc = LEN_L;
			close_spec(8'd0, ST_END, lenc);
			return;
		end
		forever begin
			case (ph)
				PH_FLAGS: begin
					case (c)
						"-": begin fl[FLAG_MINUS] = 1'b1; return; end
						"+": begin fl[FLAG_PLUS] = 1'b1; return; end
						"#": begin fl[FLAG_ALT] = 1'b1; return; end
						" ": begin fl[FLAG_SPACE] = 1'b1; return; end
						"0": begin fl[FLAG_ZERO] = 1'b1; return; end
						default: ph = PH_WDIG;
					endcase
				end
				PH_WDIG: begin
					if (is_digit(c)) begin
						wacc = add_digit(wacc, c);
						return;
					end
					if (c == "*") begin
						wm = ARG_STAR;
						wacc = '0;
						ph = PH_WSTAR;
						return;
					end
					if (c == "$") begin
						wm = ARG_POS;
						widx = wacc;
						wacc = '0;
						ph = PH_PDOT;
						return;
					end
					ph = PH_PDOT;
				end
				PH_WSTAR: begin
					ph = PH_PDOT;
					if (c == "$") begin
						wm = ARG_POS;
						widx = '0;
						return;
					end
				end
				PH_PDOT: begin
					if (c == ".") begin
						pseen = 1'b1;
						ph = PH_PDIG;
						return;
					end
					ph = PH_LEN;
				end
				PH_PDIG: begin
					if (is_digit(c)) begin
						pacc = add_digit(pacc, c);
						return;
					end
					if (c == "*") begin
						pm = ARG_STAR;
						pacc = '0;
						ph = PH_PSTAR;
						return;
					end
					if (c == "$") begin
						pm = ARG_POS;
						pidx = pacc;
						pacc = '0;
						ph = PH_LEN;
						return;
					end
					ph = PH_LEN;
				end
				PH_PSTAR: begin
					ph = PH_LEN;
					if (c == "$") begin
						pm = ARG_POS;
						pidx = '0;
						return;
					end
				end
				PH_LEN: begin
					case (c)
						"h": begin ph = PH_AFTER_H; return; end
						"l": begin ph = PH_AFTER_L; return; end
						"z": begin lenc = LEN_Z; ph = PH_CONV; return; end
						"j": begin lenc = LEN_J; ph = PH_CONV; return; end
						"L": begin lenc = LEN_BIGL; ph = PH_CONV; return; end
						default: ph = PH_CONV;
					endcase
				end
				PH_AFTER_H: begin
					ph = PH_CONV;
					if (c == "h") begin
						lenc = LEN_HH;
						return;
					end
					lenc = LEN_H;
				end
				PH_AFTER_L: begin
					ph = PH_CONV;
					if (c == "l") begin
						lenc = LEN_LL;
						return;
					end
					lenc = LEN_L;
				end
				default: begin
					if (known_conv(c))
						close_spec(c, ST_VALID, lenc);
					else
						close_spec(c, ST_LITERAL, LEN_NONE);
					return;
				end
			endcase
		end
	endtask

	// ---------------- request generation ----------------

	task automatic push_char(input logic [7:0] c, input logic eot, input logic hold);
		char_req_t r;
		r.c = c;
		r.eot = eot;
		r.hold = hold;
		char_q.push_back(r);
		total_chars++;
	endtask

	task automatic push_text(input string s);
		for (int i = 0; i < s.len(); i++)
			push_char(s[i], 1'b0, 1'b0);
	endtask

	// End of text, either flagged or as a NUL character
	task automatic push_end();
		if ($urandom_range(1))
			push_char(8'($urandom_range(255)), 1'b1, 1'b0);
		else
			push_char(8'd0, 1'b0, 1'b0);
	endtask

	task automatic push_digits(input int n);
		repeat (n) push_char(8'("0" + $urandom_range(9)), 1'b0, 1'b0);
	endtask

	// Width or precision section: digits, star, positional, or nothing
	task automatic gen_number_field();
		case ($urandom_range(6))
			0: ;
			1: begin
				push_char(8'("1" + $urandom_range(8)), 1'b0, 1'b0);
				push_digits($urandom_range(2));
			end
			2: push_digits($urandom_range(5, 7));
			3: push_char("*", 1'b0, 1'b0);
			4: push_text("*$");
			5: begin
				push_digits($urandom_range(1, 3));
				push_char("$", 1'b0, 1'b0);
			end
			default: begin
				// digits then star: digits get dropped
				push_digits($urandom_range(1, 2));
				push_char("*", 1'b0, 1'b0);
			end
		endcase
	endtask

	// One specifier with random content, sometimes cut short
	task automatic gen_spec(input logic hold);
		int cut;
		cut = ($urandom_range(9) == 0) ? $urandom_range(1, 4) : 0;
		if ($urandom_range(99) < 85)
			push_char("%", 1'b0, hold);
		else
			push_char(8'($urandom_range(1, 255)), 1'b0, hold);
		if (cut == 1) begin
			push_end();
			return;
		end
		repeat ($urandom_range(3))
			push_char(FLAG_SET[$urandom_range(FLAG_SET.len() - 1)], 1'b0, 1'b0);
		gen_number_field();
		if (cut == 2) begin
			push_end();
			return;
		end
		if ($urandom_range(1)) begin
			push_char(".", 1'b0, 1'b0);
			gen_number_field();
		end
		if (cut == 3) begin
			push_end();
			return;
		end
		case ($urandom_range(7))
			0: ;
			1: push_text("h");
			2: push_text("hh");
			3: push_text("l");
			4: push_text("ll");
			5: push_text("z");
			6: push_text("j");
			default: push_text("L");
		endcase
		if (cut == 4) begin
			push_end();
			return;
		end
		// closing character: valid conversion, literal, or end of text
		case ($urandom_range(9))
			0, 1: push_char(8'($urandom_range(1, 255)), 1'b0, 1'b0);
			2: push_end();
			default: push_char(CONV_SET[$urandom_range(CONV_SET.len() - 1)], 1'b0, 1'b0);
		endcase
	endtask

	// ---------------- request driver ----------------

	always @(posedge clk) begin : drive_proc
		char_req_t nxt;
		logic slot_free;
		logic calm;
		if (!arst_n) begin
			item_valid <= 1'b0;
		end else begin
			slot_free = !item_valid || item_ready;
			if (item_valid && item_ready) begin
				parse_char(ch, end_of_text);
				chars_sent++;
			end
			calm = chars_sent >= CALM_FROM && chars_sent < CALM_TO;
			if (slot_free) begin
				if (char_q.size() != 0 && !(char_q[0].hold && spec_q.size() != 0) &&
						(calm || $urandom_range(99) >= IDLE_PCT)) begin
					nxt = char_q.pop_front();
					item_valid <= 1'b1;
					ch <= nxt.c;
					end_of_text <= nxt.eot;
				end else begin
					item_valid <= 1'b0;
				end
			end
		end
	end

	// ---------------- result monitor ----------------

	task automatic cmp_field(input string name, input logic [31:0] exp, input logic [31:0] act);
		if (exp !== act) begin
			$display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, exp, act);
			errors++;
		end
	endtask

	task automatic check_result();
		spec_t e;
		if (spec_q.size() == 0) begin
			$display("%0t: result with nothing expected: conversion %0h status %0h",
				$time, conversion, status);
			errors++;
			return;
		end
		e = spec_q.pop_front();
		cmp_field("flag_bits", 32'(e.flags), 32'(flag_bits));
		cmp_field("width", 32'(e.wval), 32'(width));
		cmp_field("width_arg_mode", 32'(e.wmode), 32'(width_arg_mode));
		cmp_field("width_arg_index", 32'(e.widx), 32'(width_arg_index));
		cmp_field("precision", 32'(e.pval), 32'(precision));
		cmp_field("precision_present", 32'(e.pseen), 32'(precision_present));
		cmp_field("precision_arg_mode", 32'(e.pmode), 32'(precision_arg_mode));
		cmp_field("precision_arg_index", 32'(e.pidx), 32'(precision_arg_index));
		cmp_field("length_code", 32'(e.len), 32'(length_code));
		cmp_field("conversion", 32'(e.conv), 32'(conversion));
		cmp_field("status", 32'(e.status), 32'(status));
		case (e.status)
			ST_VALID: n_valid++;
			ST_LITERAL: n_literal++;
			default: n_ended++;
		endcase
	endtask

	always @(posedge clk) begin : collect_proc
		logic calm;
		if (!arst_n) begin
			result_ready <= 1'b0;
		end else begin
			if (result_valid && result_ready)
				check_result();
			// one long hold-off so the block backs up into its input
			if (!hold_done && chars_sent >= HOLD_OFF_AT) begin
				hold_done = 1'b1;
				hold_left = HOLD_OFF_CYCLES;
			end
			calm = chars_sent >= CALM_FROM && chars_sent < CALM_TO;
			if (hold_left != 0) begin
				hold_left--;
				result_ready <= 1'b0;
			end else begin
				result_ready <= calm || $urandom_range(99) >= IDLE_PCT;
			end
		end
	end

	// ---------------- stimulus and end of run ----------------

	initial begin
		// end of text and NUL while idle: no result
		push_char(8'hff, 1'b1, 1'b0);
		push_char(8'd0, 1'b0, 1'b0);
		// all flags, saturated width, positional star precision, ll, last conversion
		push_text("%-+# 070000.*$llB");
		// digits then star, then end right after a single h
		push_text("%5*h");
		push_char(8'h5a, 1'b1, 1'b0);
		// literal with the top character code
		push_char("%", 1'b0, 1'b0);
		push_char(8'hff, 1'b0, 1'b0);

		while (total_chars < 520) begin
			if ($urandom_range(9) == 0) begin
				// noise burst, closed by an end so the next specifier starts clean
				repeat ($urandom_range(2, 6))
					push_char(8'($urandom_range(255)), $urandom_range(7) == 0, 1'b0);
				push_char(8'($urandom_range(255)), 1'b1, 1'b0);
			end
			// the first few specifiers past the mark wait for the results to drain
			if (total_chars >= PAUSE_AT && pause_specs != 0) begin
				pause_specs--;
				gen_spec(1'b1);
			end else begin
				gen_spec(1'b0);
			end
		end

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		while (char_q.size() != 0 || item_valid)
			@(posedge clk);
		while (spec_q.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);

		$display("Sent %0d characters; checked %0d valid, %0d literal, %0d text-end specifiers",
			chars_sent, n_valid, n_literal, n_ended);
		$display("Run included a %0d-cycle result hold-off and a drain pause on input",
			HOLD_OFF_CYCLES);
		if (errors == 0 && spec_q.size() == 0)
			$display("tb_printf_format_spec_parser_core passed");
		else
			$display("tb_printf_format_spec_parser_core failed");
		$finish;
	end

	initial begin
		#400000;
		$display("Timeout with %0d specifiers still expected", spec_q.size());
		$display("tb_printf_format_spec_parser_core failed");
		$finish;
	end

endmodule
